[design/ubss_pkg.sv]
// Shared types and constants of the utilization band server selector.
// Used by ubss_ctrl, ubss_dp and the top level; no dependencies.
`default_nettype none
package ubss_pkg;

  localparam int NSRV        = 16;
  localparam int IW          = 4;
  localparam int UW          = 18;
  localparam int BW          = 22;
  localparam int DVW         = 28;
  localparam int DSW         = 7;
  localparam int MAX_SAMPLES = 64;
  localparam int SANE_MAX    = 160000;
  localparam int UTIL_MAX    = 262143;
  localparam int BAND_MAX    = 4194303;
  localparam int OUT_CAP     = 16;

  localparam logic [2:0] CFG_ACTIVE = 3'd0;
  localparam logic [2:0] CFG_WEIGHT = 3'd1;
  localparam logic [2:0] CFG_THRESH = 3'd2;
  localparam logic [2:0] CFG_LOWF   = 3'd3;
  localparam logic [2:0] CFG_HIGHF  = 3'd4;

  typedef enum logic [1:0] {
    OP_SEL     = 2'd0,
    OP_BATCH   = 2'd1,
    OP_UPD     = 2'd2,
    OP_REBUILD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INBAND   = 3'd0,
    ST_FALLBACK = 3'd1,
    ST_NONE     = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_SKIPPED  = 3'd4,
    ST_REJECTED = 3'd5,
    ST_REBUILT  = 3'd6
  } st_t;

  typedef enum logic [2:0] {
    OSEL_SELECT  = 3'd0,
    OSEL_BATCH   = 3'd1,
    OSEL_NONE    = 3'd2,
    OSEL_REJECT  = 3'd3,
    OSEL_SKIP    = 3'd4,
    OSEL_UPDATE  = 3'd5,
    OSEL_REBUILD = 3'd6
  } osel_t;

  typedef struct packed {
    logic  latch;
    logic  scan_clr;
    logic  scan_step;
    logic  take;
    logic  mul_upd1;
    logic  mul_upd2;
    logic  mul_rb;
    logic  rb_hi;
    logic  div_start;
    logic  div_upd;
    logic  div_step;
    logic  store_low;
    logic  store_high;
    logic  zero_band;
    logic  nv_zero;
    logic  write_util;
    logic  out_load;
    osel_t out_sel;
    logic  out_last;
  } ubss_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic batch_zero;
    logic batch_last;
    logic reject;
    logic skip;
    logic scnt_zero;
    logic act_zero;
    logic div_done;
    logic out_free;
  } ubss_stat_t;

endpackage
`default_nettype wire

[design/ubss_ctrl.sv]
// Sequencer of the utilization band server selector: walks each operation
// through the scan, multiply, divide and result steps it uses. Depends on ubss_pkg.
`default_nettype none
module ubss_ctrl import ubss_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  output logic            in_ready,
  input  wire ubss_stat_t stat,
  output ubss_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SEL_OUT, S_BAT_OUT, S_UPD_CHK, S_UPD_MUL1, S_UPD_MUL2,
    S_DIV_LD, S_DIV, S_DIV_END, S_UPD_OUT, S_RB_CHK, S_RB_MUL, S_RB_OUT
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   hi_r, hi_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    hi_nxt    = hi_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = op_t'(in_op);
          if (op_t'(in_op) == OP_UPD) state_nxt = S_UPD_CHK;
          else                        state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          case (op_r)
            OP_SEL:   state_nxt = S_SEL_OUT;
            OP_BATCH: state_nxt = S_BAT_OUT;
            default:  state_nxt = S_RB_CHK;
          endcase
        end
      end
      S_SEL_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_SELECT;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_BAT_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.batch_zero) begin
            cmd.out_sel  = OSEL_NONE;
            cmd.out_last = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.out_sel  = OSEL_BATCH;
            cmd.out_last = stat.batch_last;
            cmd.take     = 1'b1;
            if (stat.batch_last) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
        end
      end
      S_UPD_CHK: begin
        if (stat.out_free) begin
          if (stat.reject) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_REJECT;
            cmd.out_last = 1'b1;
            state_nxt    = S_IDLE;
          end else if (stat.skip) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_SKIP;
            cmd.out_last = 1'b1;
            state_nxt    = S_IDLE;
          end else if (stat.scnt_zero) begin
            cmd.nv_zero    = 1'b1;
            cmd.write_util = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_sel    = OSEL_UPDATE;
            cmd.out_last   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_UPD_MUL1;
          end
        end
      end
      S_UPD_MUL1: begin
        cmd.mul_upd1 = 1'b1;
        state_nxt    = S_UPD_MUL2;
      end
      S_UPD_MUL2: begin
        cmd.mul_upd2 = 1'b1;
        state_nxt    = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_start = 1'b1;
        cmd.div_upd   = (op_r == OP_UPD);
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_DIV_END;
      end
      S_DIV_END: begin
        if (op_r == OP_UPD) begin
          state_nxt = S_UPD_OUT;
        end else if (!hi_r) begin
          cmd.store_low = 1'b1;
          hi_nxt        = 1'b1;
          state_nxt     = S_RB_MUL;
        end else begin
          cmd.store_high = 1'b1;
          state_nxt      = S_RB_OUT;
        end
      end
      S_UPD_OUT: begin
        if (stat.out_free) begin
          cmd.write_util = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_sel    = OSEL_UPDATE;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RB_CHK: begin
        if (stat.act_zero) begin
          cmd.zero_band = 1'b1;
          state_nxt     = S_RB_OUT;
        end else begin
          hi_nxt    = 1'b0;
          state_nxt = S_RB_MUL;
        end
      end
      S_RB_MUL: begin
        cmd.mul_rb = 1'b1;
        cmd.rb_hi  = hi_r;
        state_nxt  = S_DIV_LD;
      end
      S_RB_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_REBUILD;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_SEL;
      hi_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule
`default_nettype wire

[design/ubss_dp.sv]
// Datapath of the utilization band server selector: config registers,
// utilization table, scan unit, multipliers, serial divider, result register.
// Depends on ubss_pkg; driven by ubss_ctrl.
`default_nettype none
module ubss_dp import ubss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ubss_cmd_t         cmd,
  output ubss_stat_t             stat,
  input  wire logic [3:0]        in_server_index,
  input  wire logic signed [18:0] in_average_value,
  input  wire logic [23:0]       in_sample_sum,
  input  wire logic [6:0]        in_sample_count,
  input  wire logic [4:0]        in_batch_count,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [17:0]       cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic [3:0]             out_server_out,
  output logic [21:0]            out_value_out,
  output logic                   out_last
);

  logic [NSRV-1:0] active_r;
  logic [8:0]      weight_r;
  logic [17:0]     thr_r;
  logic [11:0]     lf_r, hf_r;

  logic [UW-1:0]   util_r [NSRV];
  logic [BW-1:0]   band_low_r, band_high_r;

  logic [IW-1:0]   idx_r;
  logic [18:0]     avg_r;
  logic [23:0]     ssum_r;
  logic [6:0]      scnt_r;
  logic [4:0]      want_r;

  logic [IW-1:0]   scan_i_r, best_i_r, top_i_r;
  logic [UW-1:0]   best_u_r, top_u_r;
  logic            best_v_r, top_v_r;
  logic [4:0]      cand_cnt_r, n_r, cnt_r;
  logic [NSRV-1:0] taken_r;
  logic [BW-1:0]   sum_r;

  logic [26:0]     m1_r;
  logic [32:0]     wsum_r;
  logic [35:0]     numer_r;
  logic [DVW-1:0]  dq_r;
  logic [DSW-1:0]  rem_r, div_d_r;
  logic [4:0]      dcnt_r;

  logic            out_valid_r, out_last_r;
  st_t             status_r;
  logic [IW-1:0]   srv_r;
  logic [BW-1:0]   val_r;

  logic [IW-1:0]   rd_addr;
  logic [UW-1:0]   cur, avg18, absd, uq_sat, nv;
  logic [BW-1:0]   bq_sat;
  logic            act, inb, cand, top_act, dge;
  logic [8:0]      w_eff;
  logic [4:0]      limit;
  logic [DSW:0]    trial;
  st_t             o_status;
  logic [IW-1:0]   o_srv;
  logic [BW-1:0]   o_val;

  always_comb begin
    rd_addr = cmd.scan_step ? scan_i_r : idx_r;
    cur     = util_r[rd_addr];
    act     = active_r[scan_i_r];
    inb     = ({4'b0, cur} >= band_low_r) && ({4'b0, cur} <= band_high_r);
    cand    = act && inb && !taken_r[scan_i_r];
    top_act = active_r[top_i_r];
    w_eff   = (weight_r > 9'd256) ? 9'd256 : weight_r;
    limit   = (want_r > 5'(OUT_CAP)) ? 5'(OUT_CAP) : want_r;
    uq_sat  = (dq_r > DVW'(UTIL_MAX)) ? UW'(UTIL_MAX) : dq_r[UW-1:0];
    bq_sat  = (dq_r > DVW'(BAND_MAX)) ? BW'(BAND_MAX) : dq_r[BW-1:0];
    nv      = cmd.nv_zero ? '0 : uq_sat;
    avg18   = avg_r[UW-1:0];
    absd    = (avg18 >= cur) ? (avg18 - cur) : (cur - avg18);
    trial   = {rem_r, dq_r[DVW-1]};
    dge     = trial >= {1'b0, div_d_r};
  end

  always_comb begin
    stat.scan_last  = (scan_i_r == IW'(NSRV - 1));
    stat.batch_zero = (limit == 5'd0) || (cand_cnt_r == 5'd0);
    stat.batch_last = (cand_cnt_r == 5'd1) || ((n_r + 5'd1) == limit);
    stat.reject     = ({1'b0, idx_r} >= 5'(NSRV)) || (scnt_r > 7'(MAX_SAMPLES)) ||
                      avg_r[18] || (avg_r > 19'(SANE_MAX));
    stat.skip       = (absd <= thr_r);
    stat.scnt_zero  = (scnt_r == 7'd0);
    stat.act_zero   = (cnt_r == 5'd0);
    stat.div_done   = (dcnt_r == 5'(DVW - 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    o_status = ST_NONE;
    o_srv    = '0;
    o_val    = '0;
    case (cmd.out_sel)
      OSEL_SELECT: begin
        if (best_v_r) begin
          o_status = ST_INBAND;
          o_srv    = best_i_r;
          o_val    = {4'b0, best_u_r};
        end else if (top_act) begin
          o_status = ST_FALLBACK;
          o_srv    = top_i_r;
          o_val    = {4'b0, top_u_r};
        end
      end
      OSEL_BATCH: begin
        o_status = ST_INBAND;
        o_srv    = best_i_r;
        o_val    = {4'b0, best_u_r};
      end
      OSEL_REJECT: begin
        o_status = ST_REJECTED;
        o_srv    = idx_r;
      end
      OSEL_SKIP: begin
        o_status = ST_SKIPPED;
        o_srv    = idx_r;
        o_val    = {4'b0, cur};
      end
      OSEL_UPDATE: begin
        o_status = ST_UPDATED;
        o_srv    = idx_r;
        o_val    = {4'b0, nv};
      end
      OSEL_REBUILD: begin
        o_status = ST_REBUILT;
        o_val    = band_high_r;
      end
      default: o_status = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '1;
      weight_r    <= 9'd128;
      thr_r       <= 18'd16;
      lf_r        <= 12'd128;
      hf_r        <= 12'd384;
      for (int i = 0; i < NSRV; i++) util_r[i] <= '0;
      band_low_r  <= '0;
      band_high_r <= '0;
      taken_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ACTIVE: active_r <= cfg_data[NSRV-1:0];
          CFG_WEIGHT: weight_r <= cfg_data[8:0];
          CFG_THRESH: thr_r    <= cfg_data;
          CFG_LOWF:   lf_r     <= cfg_data[11:0];
          CFG_HIGHF:  hf_r     <= cfg_data[11:0];
          default: ;
        endcase
      end

      if (cmd.latch) begin
        idx_r   <= in_server_index;
        avg_r   <= in_average_value;
        ssum_r  <= in_sample_sum;
        scnt_r  <= in_sample_count;
        want_r  <= in_batch_count;
        taken_r <= '0;
        n_r     <= '0;
      end

      if (cmd.latch || cmd.scan_clr) begin
        scan_i_r   <= '0;
        best_v_r   <= 1'b0;
        top_v_r    <= 1'b0;
        cand_cnt_r <= '0;
        sum_r      <= '0;
        cnt_r      <= '0;
      end else if (cmd.scan_step) begin
        scan_i_r <= scan_i_r + 1'b1;
        if (cand && (!best_v_r || cur > best_u_r)) begin
          best_v_r <= 1'b1;
          best_i_r <= scan_i_r;
          best_u_r <= cur;
        end
        if (cand) cand_cnt_r <= cand_cnt_r + 5'd1;
        if (!top_v_r || cur > top_u_r) begin
          top_v_r <= 1'b1;
          top_i_r <= scan_i_r;
          top_u_r <= cur;
        end
        if (act) begin
          sum_r <= sum_r + {4'b0, cur};
          cnt_r <= cnt_r + 5'd1;
        end
      end

      if (cmd.take) begin
        taken_r[best_i_r] <= 1'b1;
        n_r               <= n_r + 5'd1;
      end

      if (cmd.mul_upd1) begin
        m1_r   <= 27'(9'd256 - w_eff) * 27'(cur);
        wsum_r <= 33'(w_eff) * 33'(ssum_r);
      end
      if (cmd.mul_upd2) begin
        numer_r <= 36'(m1_r) * 36'(scnt_r) + 36'(wsum_r) + {22'b0, scnt_r, 7'b0};
      end
      if (cmd.mul_rb) begin
        numer_r <= 36'(sum_r) * 36'(cmd.rb_hi ? hf_r : lf_r) + {24'b0, cnt_r, 7'b0};
      end

      if (cmd.div_start) begin
        dq_r    <= numer_r[35:8];
        rem_r   <= '0;
        dcnt_r  <= '0;
        div_d_r <= cmd.div_upd ? scnt_r : {2'b0, cnt_r};
      end else if (cmd.div_step) begin
        dq_r   <= {dq_r[DVW-2:0], dge};
        rem_r  <= dge ? DSW'(trial - {1'b0, div_d_r}) : trial[DSW-1:0];
        dcnt_r <= dcnt_r + 5'd1;
      end

      if (cmd.zero_band) begin
        band_low_r  <= '0;
        band_high_r <= '0;
      end
      if (cmd.store_low)  band_low_r  <= bq_sat;
      if (cmd.store_high) band_high_r <= bq_sat;

      if (cmd.write_util) util_r[idx_r] <= nv;

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        status_r    <= o_status;
        srv_r       <= o_srv;
        val_r       <= o_val;
        out_last_r  <= cmd.out_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_server_out = srv_r;
  assign out_value_out  = val_r;
  assign out_last       = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free) else $error("result beat overwritten");
  a_write_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_util |-> cmd.out_load) else $error("table write without result");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < div_d_r)) else $error("divider remainder out of range");
  a_div_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (dcnt_r == 5'd0)) else $error("divider count not cleared");

endmodule
`default_nettype wire

[design/utilization_band_server_selector.sv]
// Utilization band server selector, top level: joins ubss_ctrl and ubss_dp.
// Depends on ubss_pkg.
//
// Input beats (in_valid/in_ready) carry one request: select one, select batch,
// update utilization or rebuild band. One request is worked at a time; in_ready
// is high only while idle. Results leave through a registered output channel
// (out_valid/out_ready); out_last marks the final beat of a request.
// Work per request, from acceptance to the result beat being loaded:
//   select one    one pass over 16 table entries
//   select batch  one pass per result beat
//   update        result loaded from the check step when rejected, skipped or
//                 sample count is zero, else two multiply stages and a 28-step serial divider
//   rebuild       scan plus two multiply and divide rounds; scan only when no
//                 server is active
// The next request is taken in the cycle after the final beat loads.
// A stalled receiver holds the sequencer at its next result beat.
// Config writes (cfg_valid, always ready) take effect at once; write only
// while idle. Synchronous reset restores register defaults, clears the
// utilization table and the band, and empties the output register.
`default_nettype none
module utilization_band_server_selector import ubss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_op,
  input  wire logic [3:0]        in_server_index,
  input  wire logic signed [18:0] in_average_value,
  input  wire logic [23:0]       in_sample_sum,
  input  wire logic [6:0]        in_sample_count,
  input  wire logic [4:0]        in_batch_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic [3:0]             out_server_out,
  output logic [21:0]            out_value_out,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [17:0]       cfg_data
);

  ubss_cmd_t  cmd;
  ubss_stat_t stat;

  assign cfg_ready = 1'b1;

  ubss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ubss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_server_index  (in_server_index),
    .in_average_value (in_average_value),
    .in_sample_sum    (in_sample_sum),
    .in_sample_count  (in_sample_count),
    .in_batch_count   (in_batch_count),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_server_out   (out_server_out),
    .out_value_out    (out_value_out),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

[dv/ubss_checker.sv]
// Checker for the utilization band server selector: tracks config writes, predicts
// the result beats of every accepted request and compares them against the output.
// Depends on ubss_pkg.
`default_nettype none
module ubss_checker import ubss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [3:0]  in_server_index,
  input  wire logic [18:0] in_average_value,
  input  wire logic [23:0] in_sample_sum,
  input  wire logic [6:0]  in_sample_count,
  input  wire logic [4:0]  in_batch_count,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_status,
  input  wire logic [3:0]  out_server_out,
  input  wire logic [21:0] out_value_out,
  input  wire logic        out_last,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  output int               fail_count,
  output int               beats_due
);

  localparam int DUE_DEPTH = 64;

  typedef struct packed {
    logic [2:0]  st;
    logic [3:0]  srv;
    logic [21:0] val;
    logic        last;
  } result_beat_t;

  result_beat_t due_mem [DUE_DEPTH];
  int           due_wr, due_rd;

  logic [17:0] util [NSRV];
  logic [21:0] band_lo, band_hi;
  logic [15:0] act_mask;
  logic [8:0]  blend_w;
  logic [17:0] min_change;
  logic [11:0] lo_factor, hi_factor;

  function automatic bit in_band(logic [17:0] u);
    return {4'b0, u} >= band_lo && {4'b0, u} <= band_hi;
  endfunction

  function automatic logic [21:0] scaled_mean(longint unsigned s, longint unsigned c,
                                              logic [11:0] f);
    longint unsigned den, q;
    if (c == 0) return '0;
    den = 256 * c;
    q = (s * f + den / 2) / den;
    return (q > BAND_MAX) ? 22'(BAND_MAX) : q[21:0];
  endfunction

  function automatic void push_beat(st_t st, int srv, logic [21:0] val, bit last);
    due_mem[due_wr % DUE_DEPTH] = result_beat_t'{st, 4'(srv), val, last};
    due_wr++;
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [3:0] idx,
                                 input logic [18:0] avg, input logic [23:0] ssum,
                                 input logic [6:0] scnt, input logic [4:0] want);
    int best, top, n, lim, i;
    int picked [OUT_CAP];
    bit taken [NSRV];
    longint unsigned num, den, q, sum, cnt;
    longint diff;
    logic [8:0] w;
    logic [17:0] cur, nv;
    case (op)
      OP_SEL: begin
        best = -1;
        top = -1;
        for (i = 0; i < NSRV; i++) begin
          if (act_mask[i] && in_band(util[i]) && (best < 0 || util[i] > util[best]))
            best = i;
          if (top < 0 || util[i] > util[top]) top = i;
        end
        if (best >= 0) push_beat(ST_INBAND, best, {4'b0, util[best]}, 1'b1);
        else if (act_mask[top]) push_beat(ST_FALLBACK, top, {4'b0, util[top]}, 1'b1);
        else push_beat(ST_NONE, 0, '0, 1'b1);
      end
      OP_BATCH: begin
        lim = (want > OUT_CAP) ? OUT_CAP : want;
        n = 0;
        for (i = 0; i < NSRV; i++) taken[i] = 1'b0;
        while (n < lim) begin
          best = -1;
          for (i = 0; i < NSRV; i++)
            if (!taken[i] && act_mask[i] && in_band(util[i]) &&
                (best < 0 || util[i] > util[best]))
              best = i;
          if (best < 0) break;
          taken[best] = 1'b1;
          picked[n] = best;
          n++;
        end
        if (n == 0) push_beat(ST_NONE, 0, '0, 1'b1);
        for (i = 0; i < n; i++)
          push_beat(ST_INBAND, picked[i], {4'b0, util[picked[i]]}, i == n - 1);
      end
      OP_UPD: begin
        if (scnt > MAX_SAMPLES || avg[18] || avg > SANE_MAX) begin
          push_beat(ST_REJECTED, idx, '0, 1'b1);
        end else begin
          cur = util[idx];
          diff = longint'(avg) - longint'(cur);
          if (diff < 0) diff = -diff;
          if (diff <= longint'(min_change)) begin
            push_beat(ST_SKIPPED, idx, {4'b0, cur}, 1'b1);
          end else begin
            w = (blend_w > 256) ? 9'd256 : blend_w;
            if (scnt == 0) begin
              nv = '0;
            end else begin
              den = 256 * longint'(scnt);
              num = longint'(256 - w) * cur * scnt + longint'(w) * ssum;
              q = (num + den / 2) / den;
              nv = (q > UTIL_MAX) ? 18'(UTIL_MAX) : q[17:0];
            end
            util[idx] = nv;
            push_beat(ST_UPDATED, idx, {4'b0, nv}, 1'b1);
          end
        end
      end
      default: begin
        sum = 0;
        cnt = 0;
        for (i = 0; i < NSRV; i++)
          if (act_mask[i]) begin
            sum += util[i];
            cnt++;
          end
        band_lo = scaled_mean(sum, cnt, lo_factor);
        band_hi = scaled_mean(sum, cnt, hi_factor);
        push_beat(ST_REBUILT, 0, band_hi, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_beat_t exp_b;
    if (!rst_n) begin
      for (int i = 0; i < NSRV; i++) util[i] = '0;
      band_lo = '0;
      band_hi = '0;
      act_mask = 16'hFFFF;
      blend_w = 9'd128;
      min_change = 18'd16;
      lo_factor = 12'd128;
      hi_factor = 12'd384;
      due_wr = 0;
      due_rd = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACTIVE: act_mask = cfg_data[15:0];
          CFG_WEIGHT: blend_w = cfg_data[8:0];
          CFG_THRESH: min_change = cfg_data;
          CFG_LOWF:   lo_factor = cfg_data[11:0];
          CFG_HIGHF:  hi_factor = cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_wr == due_rd) begin
          if (fail_count < 10)
            $display("mismatch: unexpected beat st=%0d srv=%0d val=%0d last=%0b",
                     out_status, out_server_out, out_value_out, out_last);
          fail_count++;
        end else begin
          exp_b = due_mem[due_rd % DUE_DEPTH];
          due_rd++;
          if (exp_b != result_beat_t'{out_status, out_server_out, out_value_out,
                                      out_last}) begin
            if (fail_count < 10)
              $display("mismatch: exp st=%0d srv=%0d val=%0d last=%0b, ",
                       exp_b.st, exp_b.srv, exp_b.val, exp_b.last,
                       "got st=%0d srv=%0d val=%0d last=%0b",
                       out_status, out_server_out, out_value_out, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_request(in_op, in_server_index, in_average_value, in_sample_sum,
                        in_sample_count, in_batch_count);
    end
    beats_due = due_wr - due_rd;
  end

endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench top for the utilization band server selector: clock, reset, request
// and config stimulus, output back-pressure, watchdog and verdict.
// Depends on ubss_pkg, ubss_checker and the block itself.
`default_nettype none
module tb import ubss_pkg::*; ;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_op;
  logic [3:0]  in_server_index;
  logic [18:0] in_average_value;
  logic [23:0] in_sample_sum;
  logic [6:0]  in_sample_count;
  logic [4:0]  in_batch_count;
  logic        out_valid, out_ready;
  logic [2:0]  out_status;
  logic [3:0]  out_server_out;
  logic [21:0] out_value_out;
  logic        out_last;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;
  int          fail_count, beats_due, stall_cycles;
  bit          hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utilization_band_server_selector uut (.*);

  ubss_checker chk (.*);

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [3:0] idx,
                          input logic [18:0] avg, input logic [23:0] ssum,
                          input logic [6:0] scnt, input logic [4:0] want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_server_index <= idx;
    in_average_value <= avg;
    in_sample_sum <= ssum;
    in_sample_count <= scnt;
    in_batch_count <= want;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (beats_due != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_req();
    int r;
    logic [1:0]  op;
    logic [18:0] avg;
    logic [6:0]  cnt;
    logic [23:0] ssum;
    r = $urandom_range(0, 19);
    op = (r < 9) ? OP_UPD : (r < 12) ? OP_REBUILD : (r < 16) ? OP_SEL : OP_BATCH;
    r = $urandom_range(0, 9);
    if (r < 6) avg = 19'($urandom_range(0, SANE_MAX));
    else if (r == 6) avg = 19'($urandom_range(SANE_MAX + 1, 262143));
    else if (r == 7) avg = 19'($urandom) | 19'h40000;
    else if (r == 8) avg = 19'($urandom_range(0, 64));
    else avg = 19'($urandom);
    r = $urandom_range(0, 9);
    cnt = (r < 7) ? 7'($urandom_range(1, 64)) : (r == 7) ? 7'd0 :
          (r == 8) ? 7'($urandom_range(65, 127)) : 7'd64;
    if ($urandom_range(0, 3) != 0) ssum = 24'($urandom_range(0, SANE_MAX) * cnt);
    else ssum = 24'($urandom);
    send_req(op, 4'($urandom), avg, ssum, cnt, 5'($urandom));
  endtask

  // output back-pressure, with one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(50, 200))
        @(posedge clk);
      out_ready <= 1'b0;
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (600) @(posedge clk);
      end else begin
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60))
          @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL utilization_band_server_selector");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_server_index = '0;
    in_average_value = '0;
    in_sample_sum = '0;
    in_sample_count = '0;
    in_batch_count = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, update corners, band and select corners
    send_req(OP_SEL, 4'd0, '0, '0, '0, '0);
    send_req(OP_REBUILD, 4'd0, '0, '0, '0, '0);
    send_req(OP_UPD, 4'd3, 19'd1600, 24'd102400, 7'd64, '0);
    send_req(OP_UPD, 4'd5, 19'd160000, 24'hFFFFFF, 7'd1, '0);
    send_req(OP_UPD, 4'd15, 19'd160001, 24'd100, 7'd1, '0);
    send_req(OP_UPD, 4'd7, 19'h7FFFF, 24'd100, 7'd1, '0);
    send_req(OP_UPD, 4'd7, 19'd500, 24'd100, 7'd65, '0);
    send_req(OP_UPD, 4'd7, 19'd500, 24'd100, 7'd127, '0);
    send_req(OP_UPD, 4'd3, 19'd1610, 24'd1610, 7'd1, '0);
    send_req(OP_UPD, 4'd9, 19'd800, 24'd2400, 7'd3, '0);
    send_req(OP_UPD, 4'd10, 19'd800, 24'd800, 7'd1, '0);
    send_req(OP_UPD, 4'd11, 19'd900, 24'd0, 7'd0, '0);
    send_req(OP_SEL, 4'd0, '0, '0, '0, '0);
    send_req(OP_REBUILD, 4'd0, '0, '0, '0, '0);
    send_req(OP_SEL, 4'd0, '0, '0, '0, '0);
    send_req(OP_BATCH, 4'd0, '0, '0, '0, 5'd0);
    send_req(OP_BATCH, 4'd0, '0, '0, '0, 5'd3);
    send_req(OP_BATCH, 4'd0, '0, '0, '0, 5'd16);
    send_req(OP_BATCH, 4'd0, '0, '0, '0, 5'd31);
    drain();
    write_reg(CFG_ACTIVE, 18'h0);
    send_req(OP_SEL, 4'd0, '0, '0, '0, '0);
    send_req(OP_BATCH, 4'd0, '0, '0, '0, 5'd4);
    send_req(OP_REBUILD, 4'd0, '0, '0, '0, '0);
    drain();
    write_reg(CFG_ACTIVE, 18'h0FFDF);
    write_reg(CFG_WEIGHT, 18'd511);
    write_reg(CFG_THRESH, 18'h3FFFF);
    write_reg(CFG_LOWF, 18'd0);
    write_reg(CFG_HIGHF, 18'd4095);
    send_req(OP_UPD, 4'd3, 19'd0, 24'd0, 7'd1, '0);
    send_req(OP_SEL, 4'd0, '0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_ACTIVE, 18'hFFFF);
          write_reg(CFG_WEIGHT, 18'd128);
          write_reg(CFG_THRESH, 18'd16);
          write_reg(CFG_LOWF, 18'd128);
          write_reg(CFG_HIGHF, 18'd384);
        end
        1: begin
          write_reg(CFG_ACTIVE, 18'($urandom));
          write_reg(CFG_WEIGHT, 18'd256);
          write_reg(CFG_THRESH, 18'd0);
          write_reg(CFG_LOWF, 18'd0);
          write_reg(CFG_HIGHF, 18'd4095);
          hold_req = 1'b1;
        end
        2: begin
          write_reg(CFG_ACTIVE, 18'($urandom));
          write_reg(CFG_WEIGHT, 18'd0);
          write_reg(CFG_THRESH, 18'($urandom_range(0, 300)));
          write_reg(CFG_LOWF, 18'd4095);
          write_reg(CFG_HIGHF, 18'd1024);
        end
        default: begin
          write_reg(CFG_ACTIVE, 18'hFFFF);
          write_reg(CFG_WEIGHT, 18'($urandom_range(0, 511)));
          write_reg(CFG_THRESH, 18'($urandom_range(0, 64)));
          write_reg(CFG_LOWF, 18'($urandom_range(0, 255)));
          write_reg(CFG_HIGHF, 18'($urandom_range(256, 4095)));
        end
      endcase
      repeat (27) rand_req();
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && beats_due == 0)
      $display("PASS utilization_band_server_selector");
    else
      $display("FAIL utilization_band_server_selector");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
design/ubss_pkg.sv
design/ubss_ctrl.sv
design/ubss_dp.sv
design/utilization_band_server_selector.sv
dv/ubss_checker.sv
dv/tb.sv
